// File: rtl/core/ctc_pkg.sv
// Shared types, widths and trigonometry tables for the circle/triangle hit test.
// No dependencies; every module of the block imports this package.
`default_nettype none

package ctc_pkg;

   localparam int COORD_W  = 16;            // Q12.4 input coordinates
   localparam int RADIUS_W = 15;
   localparam int ANGLE_W  = 16;
   localparam int TRIG_Q   = 14;            // Q1.14 cosine and sine
   localparam int TRIG_FRAC = 48;           // fraction bits of the split tables
   localparam int TRIG_W   = TRIG_FRAC + 1;
   localparam int TAB_BITS = 7;             // each table covers 7 angle bits
   localparam int TAB_DEPTH = 1 << TAB_BITS;
   localparam int ROT_W    = 19;            // rotated coordinates, Q15.4
   localparam int DIFF_W   = ROT_W + 1;

   typedef logic [TRIG_W-1:0] trig_tab_type [TAB_DEPTH];

   typedef struct packed {
      logic signed [COORD_W-1:0] circle_x;
      logic signed [COORD_W-1:0] circle_y;
      logic [RADIUS_W-1:0]       radius;
      logic signed [COORD_W-1:0] vert_a_x;
      logic signed [COORD_W-1:0] vert_a_y;
      logic signed [COORD_W-1:0] vert_b_x;
      logic signed [COORD_W-1:0] vert_b_y;
      logic signed [COORD_W-1:0] vert_c_x;
      logic signed [COORD_W-1:0] vert_c_y;
      logic signed [COORD_W-1:0] pivot_x;
      logic signed [COORD_W-1:0] pivot_y;
      logic [ANGLE_W-1:0]        angle;
   } query_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] circle_x;
      logic signed [COORD_W-1:0] circle_y;
      logic [RADIUS_W-1:0]       radius;
      logic [2:0][ROT_W-1:0]     vx;
      logic [2:0][ROT_W-1:0]     vy;
   } scene_type;

   // Elaboration only: series sine/cosine with a 60-bit fraction, rounded to 48 bits.
   function automatic logic [TRIG_W-1:0] trig_q48(input int unsigned r, input logic want_sin);
      logic [63:0]  x, x2, ct, st, cs, ss, res;
      logic [127:0] prod;
      x  = ((64'(r) * 64'h3243F6A8) << 17) + ((64'(r) * 64'h885A308D) >> 15);
      prod = 128'(x) * 128'(x);
      x2 = prod[123:60];
      ct = 64'd1 << 60;
      cs = ct;
      st = x;
      ss = x;
      for (int k = 1; k <= 14; k++) begin
         prod = 128'(ct) * 128'(x2);
         ct = prod[123:60] / 64'((2 * k - 1) * (2 * k));
         prod = 128'(st) * 128'(x2);
         st = prod[123:60] / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            cs = cs - ct;
            ss = ss - st;
         end else begin
            cs = cs + ct;
            ss = ss + st;
         end
      end
      res = want_sin ? ((ss + (64'd1 << 11)) >> 12) : ((cs + (64'd1 << 11)) >> 12);
      return res[TRIG_W-1:0];
   endfunction

   function automatic trig_tab_type build_tab(input logic want_sin, input int unsigned step);
      trig_tab_type tab;
      for (int i = 0; i < TAB_DEPTH; i++) begin
         tab[i] = trig_q48(i * step, want_sin);
      end
      return tab;
   endfunction

   // angle = hi * 128 + lo within the first quadrant
   localparam trig_tab_type COS_HI = build_tab(1'b0, TAB_DEPTH);
   localparam trig_tab_type SIN_HI = build_tab(1'b1, TAB_DEPTH);
   localparam trig_tab_type COS_LO = build_tab(1'b0, 1);
   localparam trig_tab_type SIN_LO = build_tab(1'b1, 1);

endpackage

`default_nettype wire

// File: rtl/core/ctc_sincos.sv
// Four-stage cosine/sine unit: split-table lookup, partial products, sum, round.
// Depends on ctc_pkg for the query type and the constant tables.
`default_nettype none

module ctc_sincos (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  ctc_pkg::query_type             in_query,
   output logic                           out_valid,
   output ctc_pkg::query_type             out_query,
   output logic signed [ctc_pkg::COORD_W-1:0] out_cos,
   output logic signed [ctc_pkg::COORD_W-1:0] out_sin
);
   import ctc_pkg::*;

   localparam int LO_W   = 25;
   localparam int HI_W   = TRIG_W - LO_W;
   localparam int PROD_W = 2 * TRIG_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int SHIFT  = 2 * TRIG_FRAC - TRIG_Q;
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   logic [3:0]      valid_ff;
   query_type       qry_ff [4];
   logic [TRIG_W-1:0] ta_ff [4];     // cos_hi, sin_hi, sin_hi, cos_hi
   logic [TRIG_W-1:0] tb_ff [4];     // cos_lo, sin_lo, cos_lo, sin_lo
   logic [2*HI_W-1:0]      hh_ff [4];
   logic [HI_W+LO_W-1:0]   hl_ff [4];
   logic [HI_W+LO_W-1:0]   lh_ff [4];
   logic [2*LO_W-1:0]      ll_ff [4];
   logic [PROD_W-1:0]      prod_ff [4];
   logic signed [COORD_W-1:0] cos_ff, sin_ff;
   logic signed [COORD_W-1:0] cos_in, sin_in;
   logic [SUM_W-1:0] csum, ssum;
   logic [TRIG_Q:0]  c0, s0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         qry_ff[0] <= in_query;
         qry_ff[1] <= qry_ff[0];
         qry_ff[2] <= qry_ff[1];
         qry_ff[3] <= qry_ff[2];
         ta_ff[0] <= COS_HI[in_query.angle[2*TAB_BITS-1:TAB_BITS]];
         ta_ff[1] <= SIN_HI[in_query.angle[2*TAB_BITS-1:TAB_BITS]];
         ta_ff[2] <= SIN_HI[in_query.angle[2*TAB_BITS-1:TAB_BITS]];
         ta_ff[3] <= COS_HI[in_query.angle[2*TAB_BITS-1:TAB_BITS]];
         tb_ff[0] <= COS_LO[in_query.angle[TAB_BITS-1:0]];
         tb_ff[1] <= SIN_LO[in_query.angle[TAB_BITS-1:0]];
         tb_ff[2] <= COS_LO[in_query.angle[TAB_BITS-1:0]];
         tb_ff[3] <= SIN_LO[in_query.angle[TAB_BITS-1:0]];
      end
   end

   for (genvar j = 0; j < 4; j++) begin : g_prod
      always_ff @(posedge clock) begin
         if (advance) begin
            hh_ff[j] <= ta_ff[j][TRIG_W-1:LO_W] * tb_ff[j][TRIG_W-1:LO_W];
            hl_ff[j] <= ta_ff[j][TRIG_W-1:LO_W] * tb_ff[j][LO_W-1:0];
            lh_ff[j] <= ta_ff[j][LO_W-1:0] * tb_ff[j][TRIG_W-1:LO_W];
            ll_ff[j] <= ta_ff[j][LO_W-1:0] * tb_ff[j][LO_W-1:0];
            prod_ff[j] <= (PROD_W'(hh_ff[j]) << (2 * LO_W)) + (PROD_W'(hl_ff[j]) << LO_W)
                        + (PROD_W'(lh_ff[j]) << LO_W) + PROD_W'(ll_ff[j]);
         end
      end
   end

   // cos = Ch*Cl - Sh*Sl, sin = Sh*Cl + Ch*Sl; round half up to Q1.14
   always_comb begin
      csum = SUM_W'(prod_ff[0]) - SUM_W'(prod_ff[1]) + (SUM_W'(1) << (SHIFT - 1));
      ssum = SUM_W'(prod_ff[2]) + SUM_W'(prod_ff[3]) + (SUM_W'(1) << (SHIFT - 1));
      c0 = csum[SHIFT+TRIG_Q:SHIFT];
      s0 = ssum[SHIFT+TRIG_Q:SHIFT];
      case (qry_ff[2].angle[ANGLE_W-1:ANGLE_W-2])
         QUAD_0: begin
            cos_in = $signed(COORD_W'(c0));
            sin_in = $signed(COORD_W'(s0));
         end
         QUAD_1: begin
            cos_in = -$signed(COORD_W'(s0));
            sin_in = $signed(COORD_W'(c0));
         end
         QUAD_2: begin
            cos_in = -$signed(COORD_W'(c0));
            sin_in = -$signed(COORD_W'(s0));
         end
         QUAD_3: begin
            cos_in = $signed(COORD_W'(s0));
            sin_in = -$signed(COORD_W'(c0));
         end
         default: begin
            cos_in = '0;
            sin_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_query = qry_ff[3];
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;

   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_cos <= 16'sd16384 && out_cos >= -16'sd16384))
      else $error("cosine out of Q1.14 range");
   a_sin_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_sin <= 16'sd16384 && out_sin >= -16'sd16384))
      else $error("sine out of Q1.14 range");

endmodule

`default_nettype wire

// File: rtl/core/ctc_rotate.sv
// Two-stage vertex rotation about the pivot with round-half-up to Q15.4.
// Depends on ctc_pkg for the query and scene types.
`default_nettype none

module ctc_rotate (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  ctc_pkg::query_type             in_query,
   input  logic signed [ctc_pkg::COORD_W-1:0] in_cos,
   input  logic signed [ctc_pkg::COORD_W-1:0] in_sin,
   output logic                           out_valid,
   output ctc_pkg::scene_type             out_scene
);
   import ctc_pkg::*;

   localparam int D_W = COORD_W + 1;
   localparam int M_W = D_W + COORD_W;
   localparam int S_W = M_W + 1;
   localparam int R_W = S_W - TRIG_Q;

   logic [1:0] valid_ff;
   query_type  qry_ff;
   scene_type  scene_ff;
   logic signed [COORD_W-1:0] vx [3];
   logic signed [COORD_W-1:0] vy [3];
   logic signed [M_W-1:0] xc_ff [3];
   logic signed [M_W-1:0] ys_ff [3];
   logic signed [M_W-1:0] xs_ff [3];
   logic signed [M_W-1:0] yc_ff [3];
   scene_type scene_in;

   assign vx[0] = in_query.vert_a_x;
   assign vy[0] = in_query.vert_a_y;
   assign vx[1] = in_query.vert_b_x;
   assign vy[1] = in_query.vert_b_y;
   assign vx[2] = in_query.vert_c_x;
   assign vy[2] = in_query.vert_c_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_mul
      logic signed [D_W-1:0] dx, dy;
      assign dx = D_W'(vx[i]) - D_W'(in_query.pivot_x);
      assign dy = D_W'(vy[i]) - D_W'(in_query.pivot_y);
      always_ff @(posedge clock) begin
         if (advance) begin
            xc_ff[i] <= dx * in_cos;
            ys_ff[i] <= dy * in_sin;
            xs_ff[i] <= dx * in_sin;
            yc_ff[i] <= dy * in_cos;
         end
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_round
      logic signed [S_W-1:0] sx, sy;
      logic signed [R_W-1:0] rx, ry;
      assign sx = S_W'(xc_ff[i]) - S_W'(ys_ff[i]) + (S_W'(1) << (TRIG_Q - 1));
      assign sy = S_W'(xs_ff[i]) + S_W'(yc_ff[i]) + (S_W'(1) << (TRIG_Q - 1));
      assign rx = R_W'(sx >>> TRIG_Q) + R_W'(qry_ff.pivot_x);
      assign ry = R_W'(sy >>> TRIG_Q) + R_W'(qry_ff.pivot_y);
      assign scene_in.vx[i] = rx[ROT_W-1:0];
      assign scene_in.vy[i] = ry[ROT_W-1:0];
   end

   assign scene_in.circle_x = qry_ff.circle_x;
   assign scene_in.circle_y = qry_ff.circle_y;
   assign scene_in.radius   = qry_ff.radius;

   always_ff @(posedge clock) begin
      if (advance) begin
         qry_ff   <= in_query;
         scene_ff <= scene_in;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_scene = scene_ff;

   a_valid_enters: assert property (@(posedge clock)
      !reset && advance |=> valid_ff[0] == $past(in_valid))
      else $error("valid bit lost on entry to rotation");

endmodule

`default_nettype wire

// File: rtl/core/ctc_hit_test.sv
// Six-stage geometric test: vertex distance, inside test and edge distance.
// Depends on ctc_pkg for the scene type and widths.
`default_nettype none

module ctc_hit_test (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  ctc_pkg::scene_type in_scene,
   output logic               out_valid,
   output logic               out_hit
);
   import ctc_pkg::*;

   localparam int P_W  = 2 * DIFF_W;       // one product
   localparam int Q_W  = P_W + 1;          // sum of two products
   localparam int LO_W = (Q_W + 1) / 2;
   localparam int HI_W = Q_W - LO_W;
   localparam int R2_W = 2 * RADIUS_W;
   localparam int W_W  = 2 * Q_W;

   logic [5:0] valid_ff;
   // stage 1
   logic signed [DIFF_W-1:0] qx_ff [3], qy_ff [3], ex_ff [3], ey_ff [3];
   logic [RADIUS_W-1:0] rad_ff;
   // stage 2
   logic signed [P_W-1:0] qxx_ff [3], qyy_ff [3], pxx_ff [3], pyy_ff [3];
   logic signed [P_W-1:0] exx_ff [3], eyy_ff [3], cxy_ff [3], cyx_ff [3];
   logic [R2_W-1:0] r2_ff, r2b_ff;
   // stage 3
   logic [2:0] vin_ff, inner_ff, pok_ff;
   logic [Q_W-1:0] acr_ff [3], e2_ff [3];
   // stage 4
   logic [2:0] vin4_ff, inner4_ff, pok4_ff;
   logic [2*HI_W-1:0]      chh_ff [3];
   logic [HI_W+LO_W-1:0]   chl_ff [3];
   logic [2*LO_W-1:0]      cll_ff [3];
   logic [R2_W+HI_W-1:0]   rh_ff [3];
   logic [R2_W+LO_W-1:0]   rl_ff [3];
   // stage 5
   logic [2:0] vin5_ff, inner5_ff, pok5_ff;
   logic [W_W-1:0] cr2_ff [3], rhs_ff [3];
   // stage 6
   logic hit_ff, hit_in;
   logic [2:0] near;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff <= in_scene.radius;
         r2_ff  <= rad_ff * rad_ff;
         r2b_ff <= r2_ff;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_edge
      localparam int J = (i + 1) % 3;
      logic signed [Q_W-1:0] d2, pdot, e2, cr;
      logic signed [Q_W:0]   pw, e2w;
      assign d2   = Q_W'(qxx_ff[i]) + Q_W'(qyy_ff[i]);
      assign pdot = Q_W'(pxx_ff[i]) + Q_W'(pyy_ff[i]);
      assign e2   = Q_W'(exx_ff[i]) + Q_W'(eyy_ff[i]);
      assign cr   = Q_W'(cxy_ff[i]) - Q_W'(cyx_ff[i]);
      assign pw   = (Q_W + 1)'(pdot);
      assign e2w  = (Q_W + 1)'(e2);

      always_ff @(posedge clock) begin
         if (advance) begin
            // offsets of the center and the edge from its start vertex
            qx_ff[i] <= DIFF_W'(in_scene.circle_x) - DIFF_W'($signed(in_scene.vx[i]));
            qy_ff[i] <= DIFF_W'(in_scene.circle_y) - DIFF_W'($signed(in_scene.vy[i]));
            ex_ff[i] <= DIFF_W'($signed(in_scene.vx[J])) - DIFF_W'($signed(in_scene.vx[i]));
            ey_ff[i] <= DIFF_W'($signed(in_scene.vy[J])) - DIFF_W'($signed(in_scene.vy[i]));
            // products
            qxx_ff[i] <= qx_ff[i] * qx_ff[i];
            qyy_ff[i] <= qy_ff[i] * qy_ff[i];
            pxx_ff[i] <= ex_ff[i] * qx_ff[i];
            pyy_ff[i] <= ey_ff[i] * qy_ff[i];
            exx_ff[i] <= ex_ff[i] * ex_ff[i];
            eyy_ff[i] <= ey_ff[i] * ey_ff[i];
            cxy_ff[i] <= ex_ff[i] * qy_ff[i];
            cyx_ff[i] <= ey_ff[i] * qx_ff[i];
            // sums and early flags
            vin_ff[i]   <= $unsigned(d2) <= Q_W'(r2_ff);
            inner_ff[i] <= cr <= 0;
            pok_ff[i]   <= (pw > 0) && (pw < e2w);
            acr_ff[i]   <= cr < 0 ? $unsigned(-cr) : $unsigned(cr);
            e2_ff[i]    <= $unsigned(e2);
            // split squares
            chh_ff[i] <= acr_ff[i][Q_W-1:LO_W] * acr_ff[i][Q_W-1:LO_W];
            chl_ff[i] <= acr_ff[i][Q_W-1:LO_W] * acr_ff[i][LO_W-1:0];
            cll_ff[i] <= acr_ff[i][LO_W-1:0] * acr_ff[i][LO_W-1:0];
            rh_ff[i]  <= r2b_ff * e2_ff[i][Q_W-1:LO_W];
            rl_ff[i]  <= r2b_ff * e2_ff[i][LO_W-1:0];
            // recombine
            cr2_ff[i] <= (W_W'(chh_ff[i]) << (2 * LO_W)) + (W_W'(chl_ff[i]) << (LO_W + 1))
                       + W_W'(cll_ff[i]);
            rhs_ff[i] <= (W_W'(rh_ff[i]) << LO_W) + W_W'(rl_ff[i]);
         end
      end

      assign near[i] = pok5_ff[i] && (cr2_ff[i] <= rhs_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vin4_ff   <= vin_ff;
         inner4_ff <= inner_ff;
         pok4_ff   <= pok_ff;
         vin5_ff   <= vin4_ff;
         inner5_ff <= inner4_ff;
         pok5_ff   <= pok4_ff;
      end
   end

   assign hit_in = (|vin5_ff) || (&inner5_ff) || (|near);

   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff <= hit_in;
      end
   end

   assign out_valid = valid_ff[5];
   assign out_hit   = hit_ff;

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("pipeline moved while held");

endmodule

`default_nettype wire

// File: rtl/core/circle_triangle_collision_top.sv
// Top level of the circle versus rotated triangle hit test.
// Depends on ctc_pkg, ctc_sincos, ctc_rotate and ctc_hit_test.
`default_nettype none

// One transaction carries a circle (center, radius), a triangle (three
// vertices), a pivot and an angle in 1/65536 turn; the block rotates the
// vertices about the pivot with Q1.14 cosine/sine, rounds them to Q15.4 and
// returns one transaction with hit set when the circle touches or overlaps
// the rotated triangle (vertex inside the circle, center inside a clockwise
// triangle, or an edge within the radius). The pipeline has 12 register
// stages: 4 for the cosine/sine unit, 2 for the rotation and 6 for the
// geometry test, and a new request is taken every cycle unless the pipeline
// holds. The whole pipeline holds while a result waits under rsp_stall;
// req_stall follows from that hold.
module circle_triangle_collision_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [ctc_pkg::COORD_W-1:0]  req_circle_x,
   input  logic signed [ctc_pkg::COORD_W-1:0]  req_circle_y,
   input  logic [ctc_pkg::RADIUS_W-1:0]        req_radius,
   input  logic signed [ctc_pkg::COORD_W-1:0]  req_vert_a_x,
   input  logic signed [ctc_pkg::COORD_W-1:0]  req_vert_a_y,
   input  logic signed [ctc_pkg::COORD_W-1:0]  req_vert_b_x,
   input  logic signed [ctc_pkg::COORD_W-1:0]  req_vert_b_y,
   input  logic signed [ctc_pkg::COORD_W-1:0]  req_vert_c_x,
   input  logic signed [ctc_pkg::COORD_W-1:0]  req_vert_c_y,
   input  logic signed [ctc_pkg::COORD_W-1:0]  req_pivot_x,
   input  logic signed [ctc_pkg::COORD_W-1:0]  req_pivot_y,
   input  logic [ctc_pkg::ANGLE_W-1:0]         req_angle,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit
);
   import ctc_pkg::*;

   logic      advance;
   query_type req_query;
   query_type trig_query;
   logic      trig_valid;
   logic signed [COORD_W-1:0] trig_cos, trig_sin;
   scene_type scene;
   logic      scene_valid;

   // Advance every stage unless the finished transaction is being held.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   assign req_query.circle_x = req_circle_x;
   assign req_query.circle_y = req_circle_y;
   assign req_query.radius   = req_radius;
   assign req_query.vert_a_x = req_vert_a_x;
   assign req_query.vert_a_y = req_vert_a_y;
   assign req_query.vert_b_x = req_vert_b_x;
   assign req_query.vert_b_y = req_vert_b_y;
   assign req_query.vert_c_x = req_vert_c_x;
   assign req_query.vert_c_y = req_vert_c_y;
   assign req_query.pivot_x  = req_pivot_x;
   assign req_query.pivot_y  = req_pivot_y;
   assign req_query.angle    = req_angle;

   // Look up and round the cosine/sine of the angle.
   ctc_sincos u_sincos (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_query  (req_query),
      .out_valid (trig_valid),
      .out_query (trig_query),
      .out_cos   (trig_cos),
      .out_sin   (trig_sin)
   );

   // Rotate the three vertices about the pivot.
   ctc_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (trig_valid),
      .in_query  (trig_query),
      .in_cos    (trig_cos),
      .in_sin    (trig_sin),
      .out_valid (scene_valid),
      .out_scene (scene)
   );

   // Test the circle against the rotated triangle; the last stage is the output register.
   ctc_hit_test u_hit_test (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (scene_valid),
      .in_scene  (scene),
      .out_valid (rsp_valid),
      .out_hit   (rsp_hit)
   );

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

`default_nettype wire
